// ===== rtl/calg_pkg.sv =====
// shared types and constants for the claim attempt lockout guard
package calg_pkg;

  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_OPEN    = 3'd1;
  localparam logic [2:0] ACT_CANCEL  = 3'd2;
  localparam logic [2:0] ACT_QUERY   = 3'd3;
  localparam logic [2:0] ACT_RESPOND = 3'd4;
  localparam logic [2:0] ACT_COMM    = 3'd5;
  localparam logic [2:0] ACT_FACTORY = 3'd6;

  localparam logic [2:0] RC_OK        = 3'd0;
  localparam logic [2:0] RC_NOT_READY = 3'd1;
  localparam logic [2:0] RC_INVALID   = 3'd2;
  localparam logic [2:0] RC_BUSY      = 3'd3;
  localparam logic [2:0] RC_DENIED    = 3'd4;

  localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd0;
  localparam logic [1:0] REG_INIT_LOCKOUT = 2'd1;
  localparam logic [1:0] REG_MAX_LOCKOUT  = 2'd2;
  localparam logic [1:0] REG_MAX_LEVEL    = 2'd3;

  localparam logic [3:0]  RST_MAX_ATTEMPTS = 4'd5;
  localparam logic [31:0] RST_INIT_LOCKOUT = 32'd60000;
  localparam logic [31:0] RST_MAX_LOCKOUT  = 32'd900000;
  localparam logic [3:0]  RST_MAX_LEVEL    = 4'd5;
  localparam logic [3:0]  ATTEMPT_SAT      = 4'd15;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] now_ms;
    logic [31:0] window_ms;
    logic [63:0] challenge_word0;
    logic [63:0] challenge_word1;
    logic [63:0] challenge_word2;
    logic [63:0] challenge_word3;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_code;
    logic       window_open;
    logic [3:0] status_flags;
    logic       proof_grant;
    logic [3:0] escalation;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  max_attempts;
    logic [31:0] initial_lockout_ms;
    logic [31:0] max_lockout_ms;
    logic [3:0]  max_lockout_level;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SREAD,
    ST_SCMP,
    ST_GRANT,
    ST_DOUBLE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic scan_read;
    logic scan_next;
    logic deny;
    logic grant;
    logic dbl_step;
    logic lock_apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic go_scan;
    logic scan_end;
    logic match;
    logic need_lock;
    logic dbl_done;
  } sts_t;

  function automatic logic time_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

// ===== rtl/claim_attempt_lockout_guard_unit.sv =====
// Claim attempt lockout guard top level with its configuration registers.
// One transaction is taken at a time. Every event is captured and evaluated,
// and its result is loaded into the result register once that is free. A
// respond that passes the window and attempt checks first reads and compares
// the replay ring entry by entry up to its fill level; if none matches, it
// records the challenge and, when it starts a lockout, doubles the lockout
// duration, capped at the maximum, once per escalation level above the first.
// A new event is taken while the previous result still waits.
module claim_attempt_lockout_guard_unit
  import calg_pkg::*;
#(
  parameter int REPLAY_DEPTH = 8
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_MAX_ATTEMPTS: cfg_nxt.max_attempts       = pwdata[3:0];
        REG_INIT_LOCKOUT: cfg_nxt.initial_lockout_ms = pwdata;
        REG_MAX_LOCKOUT:  cfg_nxt.max_lockout_ms     = pwdata;
        REG_MAX_LEVEL:    cfg_nxt.max_lockout_level  = pwdata[3:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_ATTEMPTS: prdata = {28'd0, cfg_r.max_attempts};
      REG_INIT_LOCKOUT: prdata = cfg_r.initial_lockout_ms;
      REG_MAX_LOCKOUT:  prdata = cfg_r.max_lockout_ms;
      REG_MAX_LEVEL:    prdata = {28'd0, cfg_r.max_lockout_level};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_attempts       <= RST_MAX_ATTEMPTS;
      cfg_r.initial_lockout_ms <= RST_INIT_LOCKOUT;
      cfg_r.max_lockout_ms     <= RST_MAX_LOCKOUT;
      cfg_r.max_lockout_level  <= RST_MAX_LEVEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  calg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  calg_dp #(
    .REPLAY_DEPTH (REPLAY_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .out_data (out_data)
  );

endmodule

// ===== rtl/calg_ctrl.sv =====
// controller state machine sequencing one transaction through the datapath
module calg_ctrl
  import calg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = sts.go_scan ? ST_SREAD : ST_DONE;
      ST_SREAD:  state_nxt = sts.scan_end ? ST_GRANT : ST_SCMP;
      ST_SCMP:   state_nxt = sts.match ? ST_DONE : ST_SREAD;
      ST_GRANT:  state_nxt = sts.need_lock ? ST_DOUBLE : ST_DONE;
      ST_DOUBLE: if (sts.dbl_done) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:   cmd.load = in_valid;
      ST_CHECK:  cmd.check = 1'b1;
      ST_SREAD:  cmd.scan_read = !sts.scan_end;
      ST_SCMP: begin
        cmd.deny      = sts.match;
        cmd.scan_next = !sts.match;
      end
      ST_GRANT:  cmd.grant = 1'b1;
      ST_DOUBLE: begin
        cmd.dbl_step   = !sts.dbl_done;
        cmd.lock_apply = sts.dbl_done;
      end
      ST_DONE:   cmd.out_load = out_free;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/calg_dp.sv =====
// datapath: claim state, replay ring memory, lockout doubling and result register
module calg_dp
  import calg_pkg::*;
#(
  parameter int REPLAY_DEPTH = 8
)(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  in_item_t  in_data,
  input  cfg_t      cfg,
  output out_item_t out_data
);

  localparam int IDX_W  = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;
  localparam int FILL_W = $clog2(REPLAY_DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(REPLAY_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(REPLAY_DEPTH);

  in_item_t            req_r;
  logic                ready_r, ready_nxt;
  logic                active_r, active_nxt;
  logic                claimed_r, claimed_nxt;
  logic [31:0]         expiry_r, expiry_nxt;
  logic [31:0]         until_r, until_nxt;
  logic [31:0]         ldur_r, ldur_nxt;
  logic [3:0]          attempt_r, attempt_nxt;
  logic [3:0]          level_r, level_nxt;
  logic [IDX_W-1:0]    ring_next_r, ring_next_nxt;
  logic [FILL_W-1:0]   ring_fill_r, ring_fill_nxt;
  logic [FILL_W-1:0]   scan_r, scan_nxt;
  logic [2:0]          code_r, code_nxt;
  logic                grant_r, grant_nxt;
  logic [31:0]         dbl_r, dbl_nxt;
  logic [3:0]          dcnt_r, dcnt_nxt;
  logic [255:0]        rd_r;
  logic [255:0]        mem [REPLAY_DEPTH];
  out_item_t           out_r;

  logic [255:0] chal;
  logic [31:0]  now;
  logic         lk_exp, locked, win_exp, act_after;
  logic [3:0]   att_after, att_inc;
  logic [4:0]   lvl_inc;
  logic [32:0]  dbl2;
  logic         lock_flag;

  assign chal = {req_r.challenge_word3, req_r.challenge_word2,
                 req_r.challenge_word1, req_r.challenge_word0};
  assign now  = req_r.now_ms;

  assign lk_exp    = (ldur_r != 32'd0) && !time_before(now, until_r);
  assign locked    = (ldur_r != 32'd0) && time_before(now, until_r);
  assign win_exp   = active_r && !time_before(now, expiry_r);
  assign act_after = active_r && !win_exp && !locked;
  assign att_after = lk_exp ? 4'd0 : attempt_r;
  assign att_inc   = (attempt_r == ATTEMPT_SAT) ? ATTEMPT_SAT : attempt_r + 4'd1;
  assign lvl_inc   = {1'b0, level_r} + 5'd1;
  assign dbl2      = {dbl_r, 1'b0};
  assign lock_flag = (ldur_r != 32'd0) && time_before(now, until_r);

  assign sts.go_scan   = (req_r.action == ACT_RESPOND) && act_after &&
                         (att_after < cfg.max_attempts);
  assign sts.scan_end  = (scan_r == ring_fill_r);
  assign sts.match     = (rd_r == chal);
  assign sts.need_lock = (att_inc >= cfg.max_attempts);
  assign sts.dbl_done  = (dcnt_r >= level_r);

  assign out_data = out_r;

  always_comb begin
    ready_nxt     = ready_r;
    active_nxt    = active_r;
    claimed_nxt   = claimed_r;
    expiry_nxt    = expiry_r;
    until_nxt     = until_r;
    ldur_nxt      = ldur_r;
    attempt_nxt   = attempt_r;
    level_nxt     = level_r;
    ring_next_nxt = ring_next_r;
    ring_fill_nxt = ring_fill_r;
    scan_nxt      = scan_r;
    code_nxt      = code_r;
    grant_nxt     = grant_r;
    dbl_nxt       = dbl_r;
    dcnt_nxt      = dcnt_r;

    if (cmd.load) begin
      code_nxt  = RC_OK;
      grant_nxt = 1'b0;
      scan_nxt  = '0;
    end

    if (cmd.check) begin
      case (req_r.action)
        ACT_INIT: begin
          ready_nxt = 1'b1;
          until_nxt = ldur_r;
        end
        ACT_OPEN: begin
          if (!ready_r) begin
            code_nxt = RC_NOT_READY;
          end else if (req_r.window_ms == 32'd0) begin
            code_nxt = RC_INVALID;
          end else begin
            if (lk_exp) begin
              attempt_nxt = '0;
              ldur_nxt    = '0;
              until_nxt   = '0;
            end
            if (locked) begin
              code_nxt = RC_BUSY;
            end else begin
              expiry_nxt    = now + req_r.window_ms;
              ring_next_nxt = '0;
              ring_fill_nxt = '0;
              active_nxt    = 1'b1;
            end
          end
        end
        ACT_CANCEL: begin
          active_nxt    = 1'b0;
          expiry_nxt    = '0;
          ring_next_nxt = '0;
          ring_fill_nxt = '0;
        end
        ACT_QUERY, ACT_RESPOND: begin
          if (win_exp) begin
            active_nxt    = 1'b0;
            expiry_nxt    = '0;
            ring_next_nxt = '0;
            ring_fill_nxt = '0;
          end
          if (lk_exp) begin
            attempt_nxt = '0;
            ldur_nxt    = '0;
            until_nxt   = '0;
          end
          if (locked) active_nxt = 1'b0;
          if (req_r.action == ACT_RESPOND) begin
            if (!act_after) begin
              code_nxt = RC_DENIED;
            end else if (att_after >= cfg.max_attempts) begin
              code_nxt = RC_BUSY;
            end
          end
        end
        ACT_COMM: begin
          if (!ready_r) begin
            code_nxt = RC_NOT_READY;
          end else begin
            claimed_nxt   = 1'b1;
            attempt_nxt   = '0;
            level_nxt     = '0;
            ldur_nxt      = '0;
            until_nxt     = '0;
            active_nxt    = 1'b0;
            expiry_nxt    = '0;
            ring_next_nxt = '0;
            ring_fill_nxt = '0;
          end
        end
        ACT_FACTORY: begin
          claimed_nxt   = 1'b0;
          attempt_nxt   = '0;
          level_nxt     = '0;
          ldur_nxt      = '0;
          until_nxt     = '0;
          active_nxt    = 1'b0;
          expiry_nxt    = '0;
          ring_next_nxt = '0;
          ring_fill_nxt = '0;
        end
        default: code_nxt = RC_INVALID;
      endcase
    end

    if (cmd.scan_next) scan_nxt = scan_r + FILL_W'(1);
    if (cmd.deny) code_nxt = RC_DENIED;

    if (cmd.grant) begin
      grant_nxt     = 1'b1;
      ring_next_nxt = (ring_next_r == LAST_IDX) ? '0 : ring_next_r + IDX_W'(1);
      if (ring_fill_r != FULL) ring_fill_nxt = ring_fill_r + FILL_W'(1);
      attempt_nxt = att_inc;
      if (att_inc >= cfg.max_attempts) begin
        level_nxt = (lvl_inc > {1'b0, cfg.max_lockout_level}) ?
                    cfg.max_lockout_level : lvl_inc[3:0];
        dbl_nxt   = cfg.initial_lockout_ms;
        dcnt_nxt  = 4'd1;
      end
    end

    if (cmd.dbl_step) begin
      dbl_nxt  = (dbl2 > {1'b0, cfg.max_lockout_ms}) ? cfg.max_lockout_ms : dbl2[31:0];
      dcnt_nxt = dcnt_r + 4'd1;
    end

    if (cmd.lock_apply) begin
      ldur_nxt   = dbl_r;
      until_nxt  = now + dbl_r;
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= 1'b0;
      active_r    <= 1'b0;
      claimed_r   <= 1'b0;
      expiry_r    <= '0;
      until_r     <= '0;
      ldur_r      <= '0;
      attempt_r   <= '0;
      level_r     <= '0;
      ring_next_r <= '0;
      ring_fill_r <= '0;
    end else begin
      ready_r     <= ready_nxt;
      active_r    <= active_nxt;
      claimed_r   <= claimed_nxt;
      expiry_r    <= expiry_nxt;
      until_r     <= until_nxt;
      ldur_r      <= ldur_nxt;
      attempt_r   <= attempt_nxt;
      level_r     <= level_nxt;
      ring_next_r <= ring_next_nxt;
      ring_fill_r <= ring_fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    scan_r  <= scan_nxt;
    code_r  <= code_nxt;
    grant_r <= grant_nxt;
    dbl_r   <= dbl_nxt;
    dcnt_r  <= dcnt_nxt;
    if (cmd.out_load) begin
      out_r.result_code  <= code_r;
      out_r.window_open  <= active_r;
      out_r.status_flags <= {lock_flag, claimed_r, ~claimed_r, active_r};
      out_r.proof_grant  <= grant_r;
      out_r.escalation   <= level_r;
    end
  end

  // replay ring
  always_ff @(posedge clk) begin
    if (cmd.grant) mem[ring_next_r] <= chal;
    if (cmd.scan_read) rd_r <= mem[scan_r[IDX_W-1:0]];
  end

endmodule
